@@ rtl/parameter_track_interpolator_assert.svh @@
// Assertion macros used by the checker file.
`ifndef PARAMETER_TRACK_INTERPOLATOR_ASSERT_SVH
`define PARAMETER_TRACK_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define PTI_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("pti assertion failed");

// Next-cycle implication, disabled in reset.
`define PTI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("pti assertion failed");

`endif

@@ rtl/pti_pkg.sv @@
package pti_pkg;

    localparam int DVD_W = 29;
    localparam int DVS_W = 12;
    localparam logic [15:0] GAIN_ONE = 16'h8000;

    localparam logic OP_PRELOAD = 1'b0;
    localparam logic OP_INTERP  = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [4:0]         channel;
        logic signed [15:0] start_value;
        logic [11:0]        start_time;
        logic signed [15:0] end_value;
        logic [11:0]        end_time;
        logic signed [15:0] steady_value;
        logic [11:0]        position;
        logic [11:0]        duration;
    } t_in_item;

    typedef struct packed {
        logic [4:0]         out_channel;
        logic signed [15:0] smoothed_value;
    } t_out_item;

endpackage

@@ rtl/pti_if.sv @@
interface pti_in_if;
    import pti_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface pti_out_if;
    import pti_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

@@ rtl/parameter_track_interpolator.sv @@
// A preload skips the ramps and the smoother; a held value or a ramp end point passes
// the ramp check and the smoother, and overlapping ramps take three ramp passes.
// Each dividing ramp adds a multiply and a pass through the restoring divider.
// The block takes no new beat until the last result is registered; a stalled result beat
// holds the block in its last state until the output register frees.
// Reset (synchronous, active low): gain to 32768, all channel smoothers read as zero.
module parameter_track_interpolator #(
    parameter int CHANNELS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    pti_in_if.sink      i_in,
    pti_out_if.source   o_out
);
    import pti_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [6:0] CH_LIM = 7'(CHANNELS);

    typedef enum logic [3:0] {
        S_IDLE, S_PLAN, S_RCHK, S_RMUL, S_RDIV0, S_RDIV, S_RADD, S_RFIN,
        S_SM1, S_SM2, S_SM3, S_DONE
    } t_state;

    typedef enum logic [1:0] {P_ONE, P_SP, P_EP, P_FADE} t_pass;

    t_state r_state;
    t_pass  r_pass;

    logic [15:0] r_gain;
    t_in_item    r_it;
    logic        r_ch_ok;
    logic        r_hit;
    logic signed [15:0] r_old_mem;
    logic signed [15:0] r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vbit;

    logic signed [15:0] r_ra, r_rb, r_rres, r_sp, r_raw, r_res;
    logic signed [13:0] r_rt;
    logic [11:0]        r_rn;
    logic signed [16:0] r_diff;
    logic signed [35:0] r_prod;
    logic signed [35:0] r_acc;
    logic               r_neg;

    logic      r_out_valid;
    t_out_item r_out;

    logic [6:0]    w_in_ch;
    logic [AW-1:0] w_in_addr;
    logic          w_in_ok;
    logic [AW-1:0] w_addr;
    logic          w_accept;

    logic signed [13:0] w_steady;
    logic signed [13:0] w_t_end;
    logic signed [13:0] w_t_ep;
    logic [11:0]        w_k;

    logic [15:0]        w_gain;
    logic [15:0]        w_gain_c;
    logic signed [17:0] w_ma, w_mb;
    logic signed [35:0] w_mp;
    logic signed [35:0] w_abs;
    logic signed [35:0] w_bias;
    logic signed [35:0] w_shr;
    logic signed [17:0] w_q;
    logic signed [15:0] w_sat;

    logic               w_div_start;
    logic               w_div_done;
    logic [DVD_W-1:0]   w_quot;

    assign w_in_ch   = {2'b00, i_in.item.channel};
    assign w_in_addr = w_in_ch[AW-1:0];
    assign w_in_ok   = w_in_ch < CH_LIM;
    assign w_addr    = AW'({2'b00, r_it.channel});
    assign w_accept  = i_in.valid && i_in.ready;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    assign w_steady = $signed({2'b00, r_it.duration}) - $signed({2'b00, r_it.start_time})
                    - $signed({2'b00, r_it.end_time});
    assign w_t_end  = $signed({2'b00, r_it.position}) + $signed({2'b00, r_it.end_time})
                    - $signed({2'b00, r_it.duration});
    assign w_t_ep   = $signed({2'b00, r_it.duration}) - $signed({2'b00, r_it.position});
    assign w_k      = (r_it.position < r_it.duration) ? r_it.position : r_it.duration;

    assign w_gain   = (r_gain > GAIN_ONE) ? GAIN_ONE : r_gain;
    assign w_gain_c = GAIN_ONE - w_gain;

    always_comb begin
        case (r_state)
            S_SM1: begin
                w_ma = $signed({2'b00, w_gain});
                w_mb = 18'(r_raw);
            end
            S_SM2: begin
                w_ma = $signed({2'b00, w_gain_c});
                w_mb = r_hit ? 18'(r_old_mem) : '0;
            end
            default: begin
                w_ma = 18'(r_diff);
                w_mb = 18'(r_rt);
            end
        endcase
    end

    assign w_mp   = w_ma * w_mb;
    assign w_abs  = r_prod[35] ? -r_prod : r_prod;
    assign w_q    = r_neg ? -$signed({1'b0, w_quot[16:0]}) : $signed({1'b0, w_quot[16:0]});
    assign w_bias = r_acc[35] ? 36'sd32767 : 36'sd0;
    assign w_shr  = (r_acc + w_bias) >>> 15;
    assign w_sat  = (w_shr > 36'sd32767) ? 16'sh7fff :
                    (w_shr < -36'sd32768) ? 16'sh8000 : w_shr[15:0];

    assign w_div_start = (r_state == S_RDIV0);

    pti_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_abs[DVD_W-1:0]),
        .i_divisor  (r_rn),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    // channel store: registered read on the input beat, write when the result leaves
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_old_mem <= r_mem[w_in_addr];
        end
        if (r_state == S_DONE && (!r_out_valid || o_out.ready) && r_ch_ok) begin
            r_mem[w_addr] <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pass      <= P_ONE;
            r_gain      <= GAIN_ONE;
            r_vbit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            if (r_out_valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_it    <= i_in.item;
                        r_ch_ok <= w_in_ok;
                        r_hit   <= w_in_ok && r_vbit[w_in_addr];
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    if (r_it.operation == OP_PRELOAD) begin
                        r_res   <= r_it.steady_value;
                        r_state <= S_DONE;
                    end else if (w_steady >= 0 && r_it.position >= r_it.start_time) begin
                        r_ra    <= r_it.steady_value;
                        r_rb    <= r_it.end_value;
                        r_rt    <= w_t_end;
                        r_rn    <= r_it.end_time;
                        r_pass  <= P_ONE;
                        r_state <= S_RCHK;
                    end else begin
                        r_ra    <= r_it.start_value;
                        r_rb    <= r_it.steady_value;
                        r_rt    <= $signed({2'b00, r_it.position});
                        r_rn    <= r_it.start_time;
                        r_pass  <= (w_steady >= 0) ? P_ONE : P_SP;
                        r_state <= S_RCHK;
                    end
                end
                S_RCHK: begin
                    if (r_rt <= 0) begin
                        r_rres  <= r_ra;
                        r_state <= S_RFIN;
                    end else if (r_rt >= $signed({2'b00, r_rn})) begin
                        r_rres  <= r_rb;
                        r_state <= S_RFIN;
                    end else begin
                        r_diff  <= 17'(r_rb) - 17'(r_ra);
                        r_state <= S_RMUL;
                    end
                end
                S_RMUL: begin
                    r_prod  <= w_mp;
                    r_neg   <= w_mp[35];
                    r_state <= S_RDIV0;
                end
                S_RDIV0: begin
                    r_state <= S_RDIV;
                end
                S_RDIV: begin
                    if (w_div_done) begin
                        r_state <= S_RADD;
                    end
                end
                S_RADD: begin
                    r_rres  <= 16'(18'(r_ra) + w_q);
                    r_state <= S_RFIN;
                end
                S_RFIN: begin
                    case (r_pass)
                        P_SP: begin
                            r_sp    <= r_rres;
                            r_ra    <= r_it.end_value;
                            r_rb    <= r_it.steady_value;
                            r_rt    <= w_t_ep;
                            r_rn    <= r_it.end_time;
                            r_pass  <= P_EP;
                            r_state <= S_RCHK;
                        end
                        P_EP: begin
                            r_ra    <= r_sp;
                            r_rb    <= r_rres;
                            r_rt    <= $signed({2'b00, w_k});
                            r_rn    <= r_it.duration;
                            r_pass  <= P_FADE;
                            r_state <= S_RCHK;
                        end
                        default: begin
                            r_raw   <= r_rres;
                            r_state <= S_SM1;
                        end
                    endcase
                end
                S_SM1: begin
                    r_prod  <= w_mp;
                    r_state <= S_SM2;
                end
                S_SM2: begin
                    r_acc   <= r_prod + w_mp;
                    r_state <= S_SM3;
                end
                S_SM3: begin
                    r_res   <= w_sat;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid          <= 1'b1;
                        r_out.out_channel    <= r_it.channel;
                        r_out.smoothed_value <= r_res;
                        if (r_ch_ok) begin
                            r_vbit[w_addr] <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/pti_div.sv @@
module pti_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [pti_pkg::DVD_W-1:0] i_dividend,
    input  logic [pti_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [pti_pkg::DVD_W-1:0] o_quotient
);
    import pti_pkg::*;

    localparam int CW = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [DVD_W-1:0] r_q;
    logic [DVS_W:0]   w_sh;
    logic             w_ge;

    assign w_sh = {r_rem, r_q[DVD_W-1]};
    assign w_ge = w_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_q   <= i_dividend;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= DVS_W'(w_sh - {1'b0, r_dvs});
            end else begin
                r_rem <= w_sh[DVS_W-1:0];
            end
            r_q <= {r_q[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ rtl/pti_checker.sv @@
`include "parameter_track_interpolator_assert.svh"

module pti_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  pti_pkg::t_out_item i_out_item
);
    import pti_pkg::*;

    // stalled result beat holds
    `PTI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_item))
    // an input beat makes the block busy
    `PTI_ASSERT_NEXT(a_busy_after_beat, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // busy only ever starts with an input beat
    `PTI_ASSERT_NOW(a_busy_needs_beat, i_clk, i_rst_n, $fell(i_in_ready), $past(i_in_valid))
    // a new result appears together with the return to ready
    `PTI_ASSERT_NOW(a_result_frees_input, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready)

endmodule

bind parameter_track_interpolator pti_checker u_pti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.item)
);

@@ tb/sv/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pti_pkg::*;

    localparam int GAP_MAX     = 17;
    localparam int TAIL_CYCLES = 150;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int CHUNK       = 65;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    pti_in_if  in_if ();
    pti_out_if out_if ();

    parameter_track_interpolator #(
        .CHANNELS(32)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // predictor state
    logic [15:0]        gain_reg;
    logic signed [15:0] smooth_mem [32];
    t_out_item          smoothed_due [$];
    t_in_item           element_q [$];

    int send_odds;
    int recv_odds;
    int send_gap;
    int recv_stall;
    int quiet;
    int beats_queued;
    int beats_in;
    int results_seen;
    int preload_cnt;
    int overlap_cnt;
    int gains_tried;
    int err_cnt;
    t_out_item due_head;

    always #4 i_clk = ~i_clk;

    function automatic longint ramp_at(longint a, longint b, longint t, longint n);
        if (t <= 0) return a;
        if (t >= n) return b;
        return a + ((b - a) * t) / n;
    endfunction

    function automatic longint track_raw(t_in_item it);
        longint sv, st, ev, et, mid, pos, dur, flat, u, sp, ep, k;
        sv   = $signed(it.start_value);
        st   = it.start_time;
        ev   = $signed(it.end_value);
        et   = it.end_time;
        mid  = $signed(it.steady_value);
        pos  = it.position;
        dur  = it.duration;
        flat = dur - (st + et);
        if (flat >= 0) begin
            if (pos < st) return ramp_at(sv, mid, pos, st);
            u = pos - st;
            if (u <= flat) return mid;
            return ramp_at(mid, ev, u - flat, et);
        end
        sp = ramp_at(sv, mid, pos, st);
        ep = ramp_at(ev, mid, dur - pos, et);
        k  = (pos < dur) ? pos : dur;
        if (dur == 0) return sp;
        return sp + ((ep - sp) * k) / dur;
    endfunction

    function automatic void predict_beat(t_in_item it);
        longint    raw, prev, a, res;
        t_out_item want;
        if (it.operation == OP_PRELOAD) begin
            res = $signed(it.steady_value);
            preload_cnt++;
        end else begin
            raw  = track_raw(it);
            a    = (gain_reg > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(gain_reg);
            prev = smooth_mem[it.channel];
            res  = (a * raw + (32768 - a) * prev) / 32768;
            if (int'(it.duration) < int'(it.start_time) + int'(it.end_time))
                overlap_cnt++;
        end
        if (res > 32767) res = 32767;
        if (res < -32768) res = -32768;
        smooth_mem[it.channel] = res[15:0];
        want.out_channel    = it.channel;
        want.smoothed_value = res[15:0];
        smoothed_due.push_back(want);
    endfunction

    function automatic t_in_item shape_element(logic op, int ch, int sv, int st, int ev,
                                               int et, int mid, int pos, int dur);
        t_in_item it;
        it.operation    = op;
        it.channel      = ch[4:0];
        it.start_value  = sv[15:0];
        it.start_time   = st[11:0];
        it.end_value    = ev[15:0];
        it.end_time     = et[11:0];
        it.steady_value = mid[15:0];
        it.position     = pos[11:0];
        it.duration     = dur[11:0];
        return it;
    endfunction

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_frames();
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'd4095;
            2, 3, 4: return 12'($urandom_range(1, 16));
            5, 6:    return 12'($urandom_range(0, 255));
            default: return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    function automatic t_in_item random_element();
        t_in_item it;
        int span;
        int dur;
        it.operation    = ($urandom_range(0, 4) == 0) ? OP_PRELOAD : OP_INTERP;
        it.channel      = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3))
                                                      : 5'($urandom_range(0, 31));
        it.start_value  = pick_value();
        it.end_value    = pick_value();
        it.steady_value = pick_value();
        it.start_time   = pick_frames();
        it.end_time     = pick_frames();
        span = int'(it.start_time) + int'(it.end_time);
        if ($urandom_range(0, 2) != 0 && span <= 4095) begin
            dur = span + $urandom_range(0, 40);
            it.duration = (dur > 4095) ? 12'd4095 : 12'(dur);
        end else begin
            it.duration = pick_frames();
        end
        if ($urandom_range(0, 5) == 0)
            it.position = pick_frames();
        else
            it.position = 12'($urandom_range(0, it.duration));
        return it;
    endfunction

    function automatic void queue_beat(t_in_item it);
        element_q.push_back(it);
        beats_queued++;
    endfunction

    task automatic feed_random(int n);
        @(negedge i_clk);
        repeat (n) queue_beat(random_element());
    endtask

    task automatic settle();
        @(negedge i_clk);
        while (beats_in != beats_queued || smoothed_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_gain(logic [15:0] g);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        gain_reg     = g;
        gains_tried++;
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap     = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_beat(in_if.item);
                beats_in++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_if.valid <= 1'b0;
                end else if (element_q.size() != 0) begin
                    in_if.item  <= element_q.pop_front();
                    in_if.valid <= 1'b1;
                    if (send_odds != 0 && $urandom_range(1, send_odds) == 1)
                        send_gap = $urandom_range(1, GAP_MAX);
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            recv_stall    = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                results_seen++;
                if (smoothed_due.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected beat ch %0d value %0d", $time,
                             out_if.item.out_channel, $signed(out_if.item.smoothed_value));
                end else begin
                    due_head = smoothed_due.pop_front();
                    if (out_if.item.out_channel !== due_head.out_channel) begin
                        err_cnt++;
                        $display("%0t: out_channel expected %0d actual %0d", $time,
                                 due_head.out_channel, out_if.item.out_channel);
                    end
                    if (out_if.item.smoothed_value !== due_head.smoothed_value) begin
                        err_cnt++;
                        $display("%0t: smoothed_value ch %0d expected %0d actual %0d",
                                 $time, due_head.out_channel,
                                 $signed(due_head.smoothed_value),
                                 $signed(out_if.item.smoothed_value));
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                out_if.ready <= 1'b0;
            end else if (recv_odds != 0 && $urandom_range(1, recv_odds) == 1) begin
                recv_stall    = $urandom_range(1, GAP_MAX) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet = 0;
        else
            quiet++;
    end

    initial begin
        wait (quiet >= QUIET_LIMIT);
        $display("parameter_track_interpolator: mismatch");
        $finish;
    end

    initial begin
        logic [15:0] g;
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        in_if.valid  = 1'b0;
        in_if.item   = '0;
        out_if.ready = 1'b0;
        gain_reg     = GAIN_ONE;
        foreach (smooth_mem[i]) smooth_mem[i] = '0;
        send_odds    = 4;
        recv_odds    = 4;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats at the reset gain, so results are the raw track
        @(negedge i_clk);
        queue_beat(shape_element(OP_PRELOAD, 0, 0, 0, 0, 0, 32767, 0, 0));
        queue_beat(shape_element(OP_PRELOAD, 31, 0, 0, 0, 0, -32768, 0, 0));
        queue_beat(shape_element(OP_PRELOAD, 9, -1, 4095, -1, 4095, -1, 4095, 4095));
        queue_beat(shape_element(OP_INTERP, 1, -160, 4, 320, 4, 800, 2, 20));
        queue_beat(shape_element(OP_INTERP, 1, -160, 4, 320, 4, 800, 10, 20));
        queue_beat(shape_element(OP_INTERP, 1, -160, 4, 320, 4, 800, 18, 20));
        queue_beat(shape_element(OP_INTERP, 1, -160, 4, 320, 4, 800, 4095, 20));
        queue_beat(shape_element(OP_INTERP, 8, 50, 0, -700, 5, 90, 3, 5));
        queue_beat(shape_element(OP_INTERP, 7, 123, 0, 456, 0, -789, 0, 0));
        queue_beat(shape_element(OP_INTERP, 2, 1000, 30, -1000, 30, 0, 17, 40));
        queue_beat(shape_element(OP_INTERP, 2, 1000, 30, -1000, 30, 0, 0, 40));
        // overlap with zero duration
        queue_beat(shape_element(OP_INTERP, 3, -500, 1, 700, 1, 20, 5, 0));
        queue_beat(shape_element(OP_INTERP, 3, -500, 1, 700, 1, 20, 0, 0));
        // overlap with position past the end
        queue_beat(shape_element(OP_INTERP, 4, 300, 100, -300, 100, 9, 4095, 50));
        queue_beat(shape_element(OP_INTERP, 5, -32768, 4095, 32767, 4095, 32767, 4094, 4095));
        queue_beat(shape_element(OP_INTERP, 6, 32767, 4095, -32768, 4095, -32768, 1, 4095));
        queue_beat(shape_element(OP_INTERP, 31, 32767, 4095, 32767, 4095, 32767, 4095, 4095));
        queue_beat(shape_element(OP_INTERP, 0, 0, 0, 0, 0, 0, 0, 0));
        queue_beat(shape_element(OP_INTERP, 30, -32768, 2048, -32768, 2047, 32767, 2048, 4095));
        settle();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       g = 16'd0;
                1:       g = 16'hffff;
                2:       g = 16'd16384;
                3:       g = 16'd1;
                4:       g = 16'd32767;
                5:       g = 16'd32769;
                6:       g = 16'($urandom_range(0, 65535));
                default: g = GAIN_ONE;
            endcase
            set_gain(g);
            if (ph == PHASES - 1) begin
                send_odds = 0;
                recv_odds = 0;
            end else begin
                send_odds = $urandom_range(0, 2) * 3;
                recv_odds = $urandom_range(0, 2) * 3;
            end
            feed_random(CHUNK);
            // sender holds off until the pipe is empty
            settle();
            feed_random(CHUNK);
            settle();
        end

        $display("%0d beats in (%0d preloads, %0d with overlapping ramps), %0d results checked",
                 beats_in, preload_cnt, overlap_cnt, results_seen);
        $display("smoothing gain written %0d times: off, full, mid, saturating and random",
                 gains_tried);
        if (err_cnt == 0)
            $display("parameter_track_interpolator: match");
        else
            $display("parameter_track_interpolator: mismatch");
        $finish;
    end

endmodule

@@ parameter_track_interpolator.f @@
+incdir+rtl
rtl/pti_pkg.sv
rtl/pti_if.sv
rtl/pti_div.sv
rtl/parameter_track_interpolator.sv
rtl/pti_checker.sv
tb/sv/tb.sv
